[sv/wfq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// WFQ run queue package
// Shared widths, codes, state encoding and controller interface types.
// ============================================================================
package wfq_pkg;

    localparam int SLOTS_DEFAULT       = 32;
    localparam int WEIGHT_BITS_DEFAULT = 12;

    localparam int VT_W        = 64;
    localparam int TICK_W      = 32;
    localparam int TW_W        = 17;
    localparam int SLOT_IN_W   = 5;
    localparam int WEIGHT_IN_W = 12;
    localparam int COUNT_OUT_W = 6;
    localparam int STATUS_W    = 2;

    localparam logic [TICK_W-1:0] TICK_RESET = 32'd1000000;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_QUEUED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;

    typedef enum logic [2:0] {
        OP_ENQUEUE = 3'd0,
        OP_DEQUEUE = 3'd1,
        OP_TICK    = 3'd2,
        OP_PICK    = 3'd3,
        OP_PREEMPT = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        RD_SLOT = 2'd0,
        RD_IDX  = 2'd1,
        RD_RUN  = 2'd2
    } rd_sel_t;

    typedef enum logic [1:0] {
        DIV_CW    = 2'd0,
        DIV_TOTAL = 2'd1,
        DIV_RDATA = 2'd2
    } div_sel_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_D_RD,
        S_D_APPLY,
        S_SW_RD,
        S_SW_WR,
        S_T_RD,
        S_T_APPLY,
        S_T_WAIT,
        S_T_WRITE,
        S_T_QWAIT,
        S_T_QAPPLY,
        S_SC_CHK,
        S_SC_DATA,
        S_SC_WAIT,
        S_SC_CMP,
        S_SC_END,
        S_PA_RD,
        S_PA_DATA,
        S_PA_WAIT,
        S_PA_SAVE,
        S_PB_DATA,
        S_PB_WAIT,
        S_PB_CMP,
        S_FIN
    } state_t;

    typedef struct packed {
        logic     latch_in;
        logic     enq_apply;
        rd_sel_t  rd_sel;
        logic     capture;
        logic     div_start;
        div_sel_t div_sel;
        logic     deq_apply;
        logic     sweep_wr;
        logic     tick_apply;
        logic     tick_write;
        logic     qv_apply;
        logic     scan_init;
        logic     idx_inc;
        logic     scan_update;
        logic     pre_save;
        logic     pre_cmp;
        logic     set_queued;
        logic     set_absent;
        logic     set_resched;
        logic     pick_fin;
        logic     tick_fin;
        logic     out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       in_range;
        logic       queued;
        logic       running_valid;
        logic       many_queued;
        logic       idx_valid;
        logic       idx_last;
        logic       div_done;
        logic       out_free;
    } ctrl_stat_t;

endpackage
`default_nettype wire

[sv/wfq_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// WFQ generic RAM
// One write port and one read port with registered read data.
// ============================================================================
module wfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[sv/wfq_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// WFQ tick divider
// Restoring divider, one quotient bit per cycle; a zero divisor counts as one.
// ============================================================================
module wfq_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [wfq_pkg::TICK_W-1:0] dividend,
    input  wire logic [wfq_pkg::TW_W-1:0]   divisor,
    output logic                            done,
    output logic      [wfq_pkg::TICK_W-1:0] quotient
);

    localparam int CNT_W = $clog2(wfq_pkg::TICK_W);

    logic                        busy_reg;
    logic                        done_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [wfq_pkg::TW_W-1:0]    rem_reg;
    logic [wfq_pkg::TW_W-1:0]    dvs_reg;
    logic [wfq_pkg::TICK_W-1:0]  quo_reg;
    logic [wfq_pkg::TW_W:0]      shifted;
    logic [wfq_pkg::TW_W:0]      diff;
    logic                        ge;

    assign shifted = {rem_reg, quo_reg[wfq_pkg::TICK_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign ge      = shifted >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(wfq_pkg::TICK_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= (divisor == '0) ? wfq_pkg::TW_W'(1) : divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[wfq_pkg::TW_W-1:0] : shifted[wfq_pkg::TW_W-1:0];
            quo_reg <= {quo_reg[wfq_pkg::TICK_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

[sv/wfq_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// WFQ datapath
// Slot table, queue totals, divider, minimum search and result registers.
// ============================================================================
module wfq_datapath #(
    parameter int SLOTS       = wfq_pkg::SLOTS_DEFAULT,
    parameter int WEIGHT_BITS = wfq_pkg::WEIGHT_BITS_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire wfq_pkg::ctrl_cmd_t              cmd,
    output wfq_pkg::ctrl_stat_t                  stat,
    input  wire logic [2:0]                      operation,
    input  wire logic [wfq_pkg::SLOT_IN_W-1:0]   slot,
    input  wire logic [wfq_pkg::WEIGHT_IN_W-1:0] new_weight,
    input  wire logic                            cfg_write_en,
    input  wire logic [wfq_pkg::TICK_W-1:0]      cfg_write_data,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic      [wfq_pkg::STATUS_W-1:0]    status,
    output logic      [wfq_pkg::SLOT_IN_W-1:0]   picked_slot,
    output logic                                 picked_valid,
    output logic                                 reschedule,
    output logic      [wfq_pkg::COUNT_OUT_W-1:0] queued_count,
    output logic      [wfq_pkg::TW_W-1:0]        weight_sum
);

    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int WB = WEIGHT_BITS;
    localparam int RW = wfq_pkg::VT_W + WB + SW;

    logic [wfq_pkg::TICK_W-1:0]      tick_reg;
    logic [SLOTS-1:0]                valid_reg;
    logic [wfq_pkg::VT_W-1:0]        qvt_reg;
    logic [wfq_pkg::TW_W-1:0]        total_reg;
    logic [CW-1:0]                   count_reg;
    logic [SW-1:0]                   run_reg;
    logic                            run_valid_reg;

    logic [2:0]                      op_reg;
    logic [wfq_pkg::SLOT_IN_W-1:0]   slot_reg;
    logic [wfq_pkg::WEIGHT_IN_W-1:0] wt_reg;

    logic [wfq_pkg::VT_W-1:0]        ent_vt_reg;
    logic [SW-1:0]                   ent_rank_reg;
    logic [SW-1:0]                   removed_reg;
    logic [SW-1:0]                   idx_reg;
    logic                            found_reg;
    logic [SW-1:0]                   best_slot_reg;
    logic [wfq_pkg::VT_W-1:0]        best_vft_reg;
    logic [SW-1:0]                   best_rank_reg;
    logic [wfq_pkg::VT_W-1:0]        a_vft_reg;

    logic [wfq_pkg::STATUS_W-1:0]    res_status_reg;
    logic                            res_resched_reg;
    logic [SW-1:0]                   res_picked_reg;
    logic                            res_pvalid_reg;

    logic                            out_valid_reg;
    logic [wfq_pkg::STATUS_W-1:0]    out_status_reg;
    logic [wfq_pkg::SLOT_IN_W-1:0]   out_picked_reg;
    logic                            out_pvalid_reg;
    logic                            out_resched_reg;
    logic [wfq_pkg::COUNT_OUT_W-1:0] out_count_reg;
    logic [wfq_pkg::TW_W-1:0]        out_total_reg;

    logic [WB-1:0]                   w_ext;
    logic [WB-1:0]                   cw;
    logic [SW-1:0]                   slot_idx;
    logic                            in_range;
    logic                            queued;

    logic                            ram_we;
    logic [SW-1:0]                   ram_waddr;
    logic [RW-1:0]                   ram_wdata;
    logic [SW-1:0]                   ram_raddr;
    logic [RW-1:0]                   ram_rdata;
    logic [wfq_pkg::VT_W-1:0]        rd_vt;
    logic [WB-1:0]                   rd_w;
    logic [SW-1:0]                   rd_rank;

    logic [wfq_pkg::TW_W-1:0]        div_divisor;
    logic                            div_done;
    logic [wfq_pkg::TICK_W-1:0]      div_q;
    logic [wfq_pkg::VT_W-1:0]        vft;
    logic                            better;

    always_comb
    begin
        w_ext = '0;
        for (int i = 0; i < WB; i++)
        begin
            if (i < wfq_pkg::WEIGHT_IN_W)
            begin
                w_ext[i] = wt_reg[i];
            end
        end
    end

    assign cw       = (w_ext == '0) ? WB'(1) : w_ext;
    assign slot_idx = SW'(slot_reg);
    assign in_range = 32'(slot_reg) < 32'(SLOTS);
    assign queued   = in_range && valid_reg[slot_idx];

    assign rd_vt   = ram_rdata[RW-1 -: wfq_pkg::VT_W];
    assign rd_w    = ram_rdata[SW +: WB];
    assign rd_rank = ram_rdata[SW-1:0];

    assign vft    = ent_vt_reg + wfq_pkg::VT_W'(div_q);
    assign better = !found_reg || (vft < best_vft_reg) ||
                    ((vft == best_vft_reg) && (ent_rank_reg < best_rank_reg));

    always_comb
    begin
        unique case (cmd.rd_sel)
            wfq_pkg::RD_SLOT: ram_raddr = slot_idx;
            wfq_pkg::RD_IDX:  ram_raddr = idx_reg;
            wfq_pkg::RD_RUN:  ram_raddr = run_reg;
            default:          ram_raddr = slot_idx;
        endcase
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = slot_idx;
        ram_wdata = {qvt_reg, cw, SW'(count_reg)};
        priority if (cmd.enq_apply)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.tick_write)
        begin
            ram_we    = 1'b1;
            ram_wdata = {vft, cw, ent_rank_reg};
        end
        else if (cmd.sweep_wr)
        begin
            ram_we    = valid_reg[idx_reg] && (rd_rank > removed_reg);
            ram_waddr = idx_reg;
            ram_wdata = {rd_vt, rd_w, rd_rank - 1'b1};
        end
    end

    always_comb
    begin
        unique case (cmd.div_sel)
            wfq_pkg::DIV_CW:    div_divisor = wfq_pkg::TW_W'(cw);
            wfq_pkg::DIV_TOTAL: div_divisor = total_reg;
            wfq_pkg::DIV_RDATA: div_divisor = wfq_pkg::TW_W'(rd_w);
            default:            div_divisor = total_reg;
        endcase
    end

    wfq_ram #(
        .WIDTH (RW),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    wfq_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (tick_reg),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg      <= wfq_pkg::TICK_RESET;
            valid_reg     <= '0;
            qvt_reg       <= '0;
            total_reg     <= '0;
            count_reg     <= '0;
            run_reg       <= '0;
            run_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                tick_reg <= cfg_write_data;
            end
            if (cmd.enq_apply)
            begin
                valid_reg[slot_idx] <= 1'b1;
                count_reg           <= count_reg + 1'b1;
                total_reg           <= total_reg + wfq_pkg::TW_W'(cw);
            end
            if (cmd.deq_apply)
            begin
                valid_reg[slot_idx] <= 1'b0;
                count_reg           <= count_reg - 1'b1;
                total_reg           <= total_reg - wfq_pkg::TW_W'(rd_w);
            end
            if (cmd.tick_apply)
            begin
                total_reg <= total_reg - wfq_pkg::TW_W'(rd_w) + wfq_pkg::TW_W'(cw);
            end
            if (cmd.qv_apply)
            begin
                qvt_reg <= qvt_reg + wfq_pkg::VT_W'(div_q);
            end
            if (cmd.pick_fin)
            begin
                run_valid_reg <= found_reg;
                if (found_reg)
                begin
                    run_reg <= best_slot_reg;
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            op_reg          <= operation;
            slot_reg        <= slot;
            wt_reg          <= new_weight;
            res_status_reg  <= wfq_pkg::ST_OK;
            res_resched_reg <= 1'b0;
            res_picked_reg  <= '0;
            res_pvalid_reg  <= 1'b0;
        end
        if (cmd.capture)
        begin
            ent_vt_reg   <= rd_vt;
            ent_rank_reg <= rd_rank;
        end
        if (cmd.deq_apply)
        begin
            removed_reg <= rd_rank;
        end
        if (cmd.scan_init)
        begin
            idx_reg   <= '0;
            found_reg <= 1'b0;
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.scan_update && valid_reg[idx_reg] && better)
        begin
            found_reg     <= 1'b1;
            best_slot_reg <= idx_reg;
            best_vft_reg  <= vft;
            best_rank_reg <= ent_rank_reg;
        end
        if (cmd.pre_save)
        begin
            a_vft_reg <= vft;
        end
        if (cmd.pre_cmp)
        begin
            res_resched_reg <= a_vft_reg < vft;
        end
        if (cmd.set_queued)
        begin
            res_status_reg <= wfq_pkg::ST_QUEUED;
        end
        if (cmd.set_absent)
        begin
            res_status_reg <= wfq_pkg::ST_ABSENT;
        end
        if (cmd.set_resched)
        begin
            res_resched_reg <= 1'b1;
        end
        if (cmd.tick_fin)
        begin
            res_resched_reg <= found_reg && (best_slot_reg != slot_idx);
        end
        if (cmd.pick_fin)
        begin
            res_pvalid_reg <= found_reg;
            res_picked_reg <= found_reg ? best_slot_reg : '0;
        end
        if (cmd.out_load)
        begin
            out_status_reg  <= res_status_reg;
            out_picked_reg  <= wfq_pkg::SLOT_IN_W'(res_picked_reg);
            out_pvalid_reg  <= res_pvalid_reg;
            out_resched_reg <= res_resched_reg;
            out_count_reg   <= wfq_pkg::COUNT_OUT_W'(count_reg);
            out_total_reg   <= total_reg;
        end
    end

    assign stat.op            = op_reg;
    assign stat.in_range      = in_range;
    assign stat.queued        = queued;
    assign stat.running_valid = run_valid_reg;
    assign stat.many_queued   = count_reg > CW'(1);
    assign stat.idx_valid     = valid_reg[idx_reg];
    assign stat.idx_last      = idx_reg == SW'(SLOTS - 1);
    assign stat.div_done      = div_done;
    assign stat.out_free      = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign picked_slot  = out_picked_reg;
    assign picked_valid = out_pvalid_reg;
    assign reschedule   = out_resched_reg;
    assign queued_count = out_count_reg;
    assign weight_sum   = out_total_reg;

endmodule
`default_nettype wire

[sv/wfq_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// WFQ controller
// Sequences each request through table reads, divisions and the slot scan.
// ============================================================================
module wfq_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire wfq_pkg::ctrl_stat_t stat,
    output wfq_pkg::ctrl_cmd_t       cmd
);

    wfq_pkg::state_t state_reg;
    wfq_pkg::state_t state_next;
    wfq_pkg::op_t    op;

    assign op = wfq_pkg::op_t'(stat.op);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wfq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wfq_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = wfq_pkg::S_DECODE;
                end
            end
            wfq_pkg::S_DECODE:
            begin
                unique case (op)
                    wfq_pkg::OP_ENQUEUE: state_next = wfq_pkg::S_FIN;
                    wfq_pkg::OP_DEQUEUE:
                        state_next = stat.queued ? wfq_pkg::S_D_RD : wfq_pkg::S_FIN;
                    wfq_pkg::OP_TICK:
                        state_next = stat.queued ? wfq_pkg::S_T_RD : wfq_pkg::S_FIN;
                    wfq_pkg::OP_PICK:    state_next = wfq_pkg::S_SC_CHK;
                    wfq_pkg::OP_PREEMPT:
                        state_next = (stat.queued && stat.running_valid) ?
                                     wfq_pkg::S_PA_RD : wfq_pkg::S_FIN;
                    default:             state_next = wfq_pkg::S_FIN;
                endcase
            end
            wfq_pkg::S_D_RD:    state_next = wfq_pkg::S_D_APPLY;
            wfq_pkg::S_D_APPLY: state_next = wfq_pkg::S_SW_RD;
            wfq_pkg::S_SW_RD:   state_next = wfq_pkg::S_SW_WR;
            wfq_pkg::S_SW_WR:
                state_next = stat.idx_last ? wfq_pkg::S_FIN : wfq_pkg::S_SW_RD;
            wfq_pkg::S_T_RD:    state_next = wfq_pkg::S_T_APPLY;
            wfq_pkg::S_T_APPLY: state_next = wfq_pkg::S_T_WAIT;
            wfq_pkg::S_T_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = wfq_pkg::S_T_WRITE;
                end
            end
            wfq_pkg::S_T_WRITE: state_next = wfq_pkg::S_T_QWAIT;
            wfq_pkg::S_T_QWAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = wfq_pkg::S_T_QAPPLY;
                end
            end
            wfq_pkg::S_T_QAPPLY:
                state_next = stat.many_queued ? wfq_pkg::S_SC_CHK : wfq_pkg::S_FIN;
            wfq_pkg::S_SC_CHK:
            begin
                priority if (stat.idx_valid)
                begin
                    state_next = wfq_pkg::S_SC_DATA;
                end
                else if (stat.idx_last)
                begin
                    state_next = wfq_pkg::S_SC_END;
                end
                else
                begin
                    state_next = wfq_pkg::S_SC_CHK;
                end
            end
            wfq_pkg::S_SC_DATA: state_next = wfq_pkg::S_SC_WAIT;
            wfq_pkg::S_SC_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = wfq_pkg::S_SC_CMP;
                end
            end
            wfq_pkg::S_SC_CMP:
                state_next = stat.idx_last ? wfq_pkg::S_SC_END : wfq_pkg::S_SC_CHK;
            wfq_pkg::S_SC_END:  state_next = wfq_pkg::S_FIN;
            wfq_pkg::S_PA_RD:   state_next = wfq_pkg::S_PA_DATA;
            wfq_pkg::S_PA_DATA: state_next = wfq_pkg::S_PA_WAIT;
            wfq_pkg::S_PA_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = wfq_pkg::S_PA_SAVE;
                end
            end
            wfq_pkg::S_PA_SAVE: state_next = wfq_pkg::S_PB_DATA;
            wfq_pkg::S_PB_DATA: state_next = wfq_pkg::S_PB_WAIT;
            wfq_pkg::S_PB_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = wfq_pkg::S_PB_CMP;
                end
            end
            wfq_pkg::S_PB_CMP:  state_next = wfq_pkg::S_FIN;
            wfq_pkg::S_FIN:
            begin
                if (stat.out_free)
                begin
                    state_next = wfq_pkg::S_IDLE;
                end
            end
            default:            state_next = wfq_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.rd_sel   = wfq_pkg::RD_SLOT;
        cmd.div_sel  = wfq_pkg::DIV_RDATA;
        in_ready     = 1'b0;
        unique case (state_reg)
            wfq_pkg::S_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.latch_in = in_valid;
            end
            wfq_pkg::S_DECODE:
            begin
                unique case (op)
                    wfq_pkg::OP_ENQUEUE:
                    begin
                        priority if (!stat.in_range)
                        begin
                            cmd.set_absent = 1'b1;
                        end
                        else if (stat.queued)
                        begin
                            cmd.set_queued = 1'b1;
                        end
                        else
                        begin
                            cmd.enq_apply = 1'b1;
                        end
                    end
                    wfq_pkg::OP_DEQUEUE, wfq_pkg::OP_TICK:
                    begin
                        cmd.set_absent = !stat.queued;
                    end
                    wfq_pkg::OP_PICK:
                    begin
                        cmd.scan_init = 1'b1;
                    end
                    wfq_pkg::OP_PREEMPT:
                    begin
                        cmd.set_absent  = !stat.queued;
                        cmd.set_resched = stat.queued && !stat.running_valid;
                    end
                    default:
                    begin
                    end
                endcase
            end
            wfq_pkg::S_D_RD, wfq_pkg::S_T_RD, wfq_pkg::S_PA_RD:
            begin
                cmd.rd_sel = wfq_pkg::RD_SLOT;
            end
            wfq_pkg::S_D_APPLY:
            begin
                cmd.deq_apply = 1'b1;
                cmd.scan_init = 1'b1;
            end
            wfq_pkg::S_SW_RD:
            begin
                cmd.rd_sel = wfq_pkg::RD_IDX;
            end
            wfq_pkg::S_SW_WR:
            begin
                cmd.sweep_wr = 1'b1;
                cmd.idx_inc  = !stat.idx_last;
            end
            wfq_pkg::S_T_APPLY:
            begin
                cmd.capture    = 1'b1;
                cmd.tick_apply = 1'b1;
                cmd.div_start  = 1'b1;
                cmd.div_sel    = wfq_pkg::DIV_CW;
            end
            wfq_pkg::S_T_WRITE:
            begin
                cmd.tick_write = 1'b1;
                cmd.div_start  = 1'b1;
                cmd.div_sel    = wfq_pkg::DIV_TOTAL;
            end
            wfq_pkg::S_T_QAPPLY:
            begin
                cmd.qv_apply  = 1'b1;
                cmd.scan_init = 1'b1;
            end
            wfq_pkg::S_SC_CHK:
            begin
                cmd.rd_sel  = wfq_pkg::RD_IDX;
                cmd.idx_inc = !stat.idx_valid && !stat.idx_last;
            end
            wfq_pkg::S_SC_DATA, wfq_pkg::S_PA_DATA, wfq_pkg::S_PB_DATA:
            begin
                cmd.capture   = 1'b1;
                cmd.div_start = 1'b1;
                cmd.div_sel   = wfq_pkg::DIV_RDATA;
            end
            wfq_pkg::S_SC_CMP:
            begin
                cmd.scan_update = 1'b1;
                cmd.idx_inc     = !stat.idx_last;
            end
            wfq_pkg::S_SC_END:
            begin
                cmd.pick_fin = (op == wfq_pkg::OP_PICK);
                cmd.tick_fin = (op == wfq_pkg::OP_TICK);
            end
            wfq_pkg::S_PA_SAVE:
            begin
                cmd.pre_save = 1'b1;
                cmd.rd_sel   = wfq_pkg::RD_RUN;
            end
            wfq_pkg::S_PB_CMP:
            begin
                cmd.pre_cmp = 1'b1;
            end
            wfq_pkg::S_FIN:
            begin
                cmd.out_load = stat.out_free;
            end
            default:
            begin
            end
        endcase
    end

endmodule
`default_nettype wire

[sv/wfq_run_queue_scheduler.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// WFQ run queue scheduler
// Weighted fair queueing run queue over a fixed set of task slots.
// ============================================================================
// Requests arrive on the input channel (operation, slot, new_weight) under
// in_valid/in_ready; each request gives exactly one result on the output
// channel under out_valid/out_ready. The tick value is written through
// cfg_write_en/cfg_write_data; the user must do so only while the block is
// idle, as the block itself does not enforce it. Requests are handled one at
// a time. Every virtual finish time needs one pass of the shared bit-serial
// divider: enqueue, unknown operations and requests that end at the first
// check need none, a preempt check needs two, a pick one per queued slot, and
// a tick two, plus one per queued slot when more than one slot is queued; a
// dequeue sweeps every slot to renumber the ranks. A new request is taken
// once the previous one is done.
// The result waits in an output register; while the receiver stalls, the
// next request is still taken and worked on, and it waits for the register.
// Reset empties the queue, clears the virtual time, weight sum and running
// slot, and sets the tick value to 1000000; the slot table needs no clear.
// ============================================================================
module wfq_run_queue_scheduler #(
    parameter int SLOTS       = wfq_pkg::SLOTS_DEFAULT,
    parameter int WEIGHT_BITS = wfq_pkg::WEIGHT_BITS_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [2:0]                      operation,
    input  wire logic [wfq_pkg::SLOT_IN_W-1:0]   slot,
    input  wire logic [wfq_pkg::WEIGHT_IN_W-1:0] new_weight,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic      [wfq_pkg::STATUS_W-1:0]    status,
    output logic      [wfq_pkg::SLOT_IN_W-1:0]   picked_slot,
    output logic                                 picked_valid,
    output logic                                 reschedule,
    output logic      [wfq_pkg::COUNT_OUT_W-1:0] queued_count,
    output logic      [wfq_pkg::TW_W-1:0]        weight_sum,
    input  wire logic                            cfg_write_en,
    input  wire logic [wfq_pkg::TICK_W-1:0]      cfg_write_data
);

    wfq_pkg::ctrl_cmd_t  cmd;
    wfq_pkg::ctrl_stat_t stat;

    wfq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    wfq_datapath #(
        .SLOTS       (SLOTS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .operation      (operation),
        .slot           (slot),
        .new_weight     (new_weight),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .picked_slot    (picked_slot),
        .picked_valid   (picked_valid),
        .reschedule     (reschedule),
        .queued_count   (queued_count),
        .weight_sum     (weight_sum)
    );

endmodule
`default_nettype wire

[test/wfq_run_queue_scheduler_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// WFQ run queue scheduler testbench
// Drives enqueue, dequeue, tick, pick and preempt requests with random gaps
// on both channels, predicts every result from a behavioral copy of the run
// queue and checks the results in order, over several tick settings.
// ============================================================================
module wfq_run_queue_scheduler_tb;

    localparam logic [2:0] OP_RSVD_LO = 3'd5;
    localparam logic [2:0] OP_RSVD_HI = 3'd7;
    localparam int NSLOT = 32;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  picked_slot;
        logic        picked_valid;
        logic        reschedule;
        logic [5:0]  queued_count;
        logic [16:0] weight_sum;
    } sched_result_t;

    class wfq_scoreboard;
        logic [31:0]   tick_value;
        bit            queued[NSLOT];
        logic [11:0]   weight[NSLOT];
        logic [63:0]   vtime[NSLOT];
        int            rank[NSLOT];
        logic [63:0]   queue_vt;
        logic [16:0]   wsum;
        int            count;
        int            run_slot;
        bit            run_valid;
        sched_result_t pending_results[$];
        int            mismatches;

        function new();
            tick_value = wfq_pkg::TICK_RESET;
            foreach (queued[i])
            begin
                queued[i] = 0;
                weight[i] = 0;
                vtime[i] = 0;
                rank[i] = 0;
            end
            queue_vt = 0;
            wsum = 0;
            count = 0;
            run_slot = 0;
            run_valid = 0;
            mismatches = 0;
        endfunction

        function logic [63:0] share(logic [16:0] d);
            return {32'd0, tick_value} / {47'd0, (d == 0) ? 17'd1 : d};
        endfunction

        function logic [63:0] finish_of(int s);
            return vtime[s] + share({5'd0, weight[s]});
        endfunction

        function bit least_finish(output int best);
            logic [63:0] bv;
            logic [63:0] v;
            bit found;
            found = 0;
            best = 0;
            bv = 0;
            for (int s = 0; s < NSLOT; s++)
            begin
                if (queued[s])
                begin
                    v = finish_of(s);
                    if (!found || v < bv || (v == bv && rank[s] < rank[best]))
                    begin
                        found = 1;
                        best = s;
                        bv = v;
                    end
                end
            end
            return found;
        endfunction

        function void note(logic [2:0] op, logic [4:0] s, logic [11:0] w);
            sched_result_t r;
            int best;
            logic [11:0] cw;
            cw = (w == 0) ? 12'd1 : w;
            r = '0;
            case (op)
                wfq_pkg::OP_ENQUEUE:
                begin
                    if (queued[s])
                        r.status = wfq_pkg::ST_QUEUED;
                    else
                    begin
                        queued[s] = 1;
                        weight[s] = cw;
                        vtime[s] = queue_vt;
                        rank[s] = count;
                        count++;
                        wsum += cw;
                    end
                end
                wfq_pkg::OP_DEQUEUE:
                begin
                    if (!queued[s])
                        r.status = wfq_pkg::ST_ABSENT;
                    else
                    begin
                        queued[s] = 0;
                        count--;
                        wsum -= weight[s];
                        for (int i = 0; i < NSLOT; i++)
                            if (queued[i] && rank[i] > rank[s])
                                rank[i]--;
                    end
                end
                wfq_pkg::OP_TICK:
                begin
                    if (!queued[s])
                        r.status = wfq_pkg::ST_ABSENT;
                    else
                    begin
                        wsum = wsum - weight[s] + cw;
                        weight[s] = cw;
                        vtime[s] += share({5'd0, cw});
                        queue_vt += share(wsum);
                        if (count > 1 && least_finish(best) && best != s)
                            r.reschedule = 1;
                    end
                end
                wfq_pkg::OP_PICK:
                begin
                    if (least_finish(best))
                    begin
                        r.picked_slot = best[4:0];
                        r.picked_valid = 1;
                        run_slot = best;
                        run_valid = 1;
                    end
                    else
                        run_valid = 0;
                end
                wfq_pkg::OP_PREEMPT:
                begin
                    if (!queued[s])
                        r.status = wfq_pkg::ST_ABSENT;
                    else if (!run_valid)
                        r.reschedule = 1;
                    else if (finish_of(s) < finish_of(run_slot))
                        r.reschedule = 1;
                end
                default: ;
            endcase
            r.queued_count = count[5:0];
            r.weight_sum = wsum;
            pending_results.push_back(r);
        endfunction

        function void check(sched_result_t got);
            sched_result_t want;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: %p", got);
                return;
            end
            want = pending_results.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: expected %p, got %p", want, got);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [2:0] operation;
    logic [4:0] slot;
    logic [11:0] new_weight;
    logic out_valid;
    logic out_ready;
    logic [1:0] status;
    logic [4:0] picked_slot;
    logic picked_valid;
    logic reschedule;
    logic [5:0] queued_count;
    logic [16:0] weight_sum;
    logic cfg_write_en;
    logic [31:0] cfg_write_data;

    wfq_scoreboard run_queue;
    bit quiet;
    int stall_cycles;

    wfq_run_queue_scheduler i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .operation(operation),
        .slot(slot),
        .new_weight(new_weight),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .picked_slot(picked_slot),
        .picked_valid(picked_valid),
        .reschedule(reschedule),
        .queued_count(queued_count),
        .weight_sum(weight_sum),
        .cfg_write_en(cfg_write_en),
        .cfg_write_data(cfg_write_data)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (out_valid && out_ready)
                run_queue.check({status, picked_slot, picked_valid, reschedule,
                                 queued_count, weight_sum});
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("FAIL wfq_run_queue_scheduler");
                $finish;
            end
        end
    end

    always @(negedge clk)
    begin
        if (!quiet && $urandom_range(0, 9) == 0)
        begin
            out_ready <= 0;
            repeat ($urandom_range(1, 3) - 1) @(negedge clk);
        end
        else
            out_ready <= 1;
    end

    task automatic send_request(logic [2:0] op, logic [4:0] s, logic [11:0] w);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            @(negedge clk);
            in_valid <= 0;
            repeat ($urandom_range(1, 3) - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1;
        operation <= op;
        slot <= s;
        new_weight <= w;
        do
            @(posedge clk);
        while (!in_ready);
        run_queue.note(op, s, w);
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 0;
        while (run_queue.pending_results.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_tick(logic [31:0] value);
        drain_results();
        cfg_write_en <= 1;
        cfg_write_data <= value;
        @(negedge clk);
        cfg_write_en <= 0;
        run_queue.tick_value = value;
    endtask

    task automatic random_requests(int n);
        logic [2:0] op;
        logic [4:0] s;
        int pick;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                op = wfq_pkg::OP_ENQUEUE;
            else if (pick < 55)
                op = wfq_pkg::OP_DEQUEUE;
            else if (pick < 75)
                op = wfq_pkg::OP_TICK;
            else if (pick < 89)
                op = wfq_pkg::OP_PICK;
            else if (pick < 97)
                op = wfq_pkg::OP_PREEMPT;
            else
                op = 3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
            if ($urandom_range(0, 9) < 7)
                s = 5'($urandom_range(0, 7));
            else
                s = 5'($urandom_range(0, 31));
            send_request(op, s, 12'($urandom_range(0, 4095)));
        end
    endtask

    initial
    begin
        run_queue = new();
        quiet = 0;
        stall_cycles = 0;
        rst_n = 0;
        in_valid = 0;
        operation = wfq_pkg::OP_PICK;
        slot = 0;
        new_weight = 1;
        out_ready = 0;
        cfg_write_en = 0;
        cfg_write_data = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        send_request(wfq_pkg::OP_PREEMPT, 5'd3, 12'd1);
        send_request(wfq_pkg::OP_PICK, 5'd0, 12'd1);
        send_request(wfq_pkg::OP_ENQUEUE, 5'd0, 12'd0);
        send_request(wfq_pkg::OP_ENQUEUE, 5'd31, 12'd4095);
        send_request(wfq_pkg::OP_ENQUEUE, 5'd0, 12'd7);
        send_request(wfq_pkg::OP_PREEMPT, 5'd31, 12'd1);
        send_request(wfq_pkg::OP_PICK, 5'd0, 12'd1);
        send_request(wfq_pkg::OP_TICK, 5'd0, 12'd1);
        send_request(wfq_pkg::OP_TICK, 5'd31, 12'd2730);
        send_request(wfq_pkg::OP_PREEMPT, 5'd31, 12'd1);
        send_request(wfq_pkg::OP_PICK, 5'd0, 12'd1);
        send_request(wfq_pkg::OP_DEQUEUE, 5'd31, 12'd1);
        send_request(wfq_pkg::OP_PREEMPT, 5'd0, 12'd1);
        send_request(wfq_pkg::OP_DEQUEUE, 5'd0, 12'd1);
        send_request(wfq_pkg::OP_DEQUEUE, 5'd0, 12'd1);
        send_request(wfq_pkg::OP_TICK, 5'd9, 12'd5);
        send_request(wfq_pkg::OP_PICK, 5'd0, 12'd1);
        send_request(wfq_pkg::OP_ENQUEUE, 5'd5, 12'd1365);
        send_request(wfq_pkg::OP_TICK, 5'd5, 12'd3);
        send_request(wfq_pkg::OP_ENQUEUE, 5'd2, 12'd100);
        send_request(wfq_pkg::OP_ENQUEUE, 5'd1, 12'd100);
        send_request(wfq_pkg::OP_PICK, 5'd0, 12'd1);
        send_request(OP_RSVD_LO, 5'd21, 12'd10);
        send_request(3'd6, 5'd10, 12'd2048);
        send_request(OP_RSVD_HI, 5'd31, 12'd4095);

        write_tick(wfq_pkg::TICK_RESET);
        random_requests(350);
        write_tick(32'd1);
        random_requests(350);
        write_tick(32'hFFFF_FFFF);
        random_requests(350);
        write_tick($urandom_range(2, 64));
        random_requests(350);
        write_tick($urandom());
        random_requests(150);
        quiet = 1;
        random_requests(200);

        drain_results();
        repeat (50) @(negedge clk);
        if (run_queue.mismatches == 0 && run_queue.pending_results.size() == 0)
            $display("PASS wfq_run_queue_scheduler");
        else
            $display("FAIL wfq_run_queue_scheduler");
        $finish;
    end
endmodule
